// ===== hw/rtl/hdsp_pkg.sv =====
// Shared types and constants for the HTTP date string parser.
`default_nettype none

package hdsp_pkg;

    // One input word: a byte of the date string plus its start mark.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       first;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic       bad_format;
        logic [2:0] weekday;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [9:0] years_since_1900;
    } out_word_t;

    localparam logic [4:0] LAST_POS = 5'd28;

    // What the back end does with a classified byte.
    localparam logic [2:0] KIND_CHECK = 3'd0;
    localparam logic [2:0] KIND_HOLD_LO = 3'd1;
    localparam logic [2:0] KIND_HOLD_SHIFT = 3'd2;
    localparam logic [2:0] KIND_DAY = 3'd3;
    localparam logic [2:0] KIND_MON = 3'd4;
    localparam logic [2:0] KIND_DIGIT = 3'd5;

    // Accumulator selects.
    localparam int unsigned NUM_FIELDS = 6;
    localparam logic [2:0] FLD_DAY = 3'd0;
    localparam logic [2:0] FLD_CENT = 3'd1;
    localparam logic [2:0] FLD_YEAR = 3'd2;
    localparam logic [2:0] FLD_HOUR = 3'd3;
    localparam logic [2:0] FLD_MIN = 3'd4;
    localparam logic [2:0] FLD_SEC = 3'd5;

    // Classified byte passed from front to back.
    typedef struct packed {
        logic       start;
        logic       last;
        logic [2:0] kind;
        logic [2:0] field;
        logic       bad;
        logic [3:0] digit;
        logic [7:0] char_byte;
    } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hdsp_front.sv =====
// Front end: tracks the byte position and classifies each byte.
`default_nettype none

module hdsp_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire hdsp_pkg::in_word_t s_data,
    output logic                  op_valid,
    input  wire logic             op_ready,
    output hdsp_pkg::op_t         op_data
);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    logic [4:0] pos_reg;
    logic [4:0] pos_next;
    logic [4:0] pos_eff;
    logic       accept;
    logic       is_last;
    logic [2:0] kind;
    logic [2:0] field;
    logic       fixed;
    logic [7:0] want;
    logic       is_digit;
    logic [7:0] digit_off;

    assign accept = s_valid && s_ready;
    assign s_ready = op_ready;
    assign op_valid = s_valid;

    // A start mark forces position zero.
    assign pos_eff = s_data.first ? 5'd0 : pos_reg;
    assign is_last = (pos_eff == hdsp_pkg::LAST_POS);
    assign pos_next = is_last ? 5'd0 : pos_eff + 5'd1;

    always_comb begin
        kind = hdsp_pkg::KIND_CHECK;
        field = hdsp_pkg::FLD_DAY;
        fixed = 1'b0;
        want = CH_SPACE;
        unique case (pos_eff)
            5'd0, 5'd8: begin
                kind = hdsp_pkg::KIND_HOLD_LO;
            end
            5'd1, 5'd9: begin
                kind = hdsp_pkg::KIND_HOLD_SHIFT;
            end
            5'd2: begin
                kind = hdsp_pkg::KIND_DAY;
            end
            5'd10: begin
                kind = hdsp_pkg::KIND_MON;
            end
            5'd3: begin
                fixed = 1'b1;
                want = CH_COMMA;
            end
            5'd4, 5'd7, 5'd11, 5'd16, 5'd25: begin
                fixed = 1'b1;
                want = CH_SPACE;
            end
            5'd19, 5'd22: begin
                fixed = 1'b1;
                want = CH_COLON;
            end
            5'd26: begin
                fixed = 1'b1;
                want = CH_G;
            end
            5'd27: begin
                fixed = 1'b1;
                want = CH_M;
            end
            5'd28: begin
                fixed = 1'b1;
                want = CH_T;
            end
            5'd5, 5'd6: begin
                kind = hdsp_pkg::KIND_DIGIT;
                field = hdsp_pkg::FLD_DAY;
            end
            5'd12, 5'd13: begin
                kind = hdsp_pkg::KIND_DIGIT;
                field = hdsp_pkg::FLD_CENT;
            end
            5'd14, 5'd15: begin
                kind = hdsp_pkg::KIND_DIGIT;
                field = hdsp_pkg::FLD_YEAR;
            end
            5'd17, 5'd18: begin
                kind = hdsp_pkg::KIND_DIGIT;
                field = hdsp_pkg::FLD_HOUR;
            end
            5'd20, 5'd21: begin
                kind = hdsp_pkg::KIND_DIGIT;
                field = hdsp_pkg::FLD_MIN;
            end
            5'd23, 5'd24: begin
                kind = hdsp_pkg::KIND_DIGIT;
                field = hdsp_pkg::FLD_SEC;
            end
            default: begin
                kind = hdsp_pkg::KIND_CHECK;
            end
        endcase
    end

    assign is_digit = (s_data.char_byte >= CH_ZERO) && (s_data.char_byte <= CH_NINE);
    assign digit_off = s_data.char_byte - CH_ZERO;

    always_comb begin
        op_data.start = (pos_eff == 5'd0);
        op_data.last = is_last;
        op_data.kind = kind;
        op_data.field = field;
        op_data.char_byte = s_data.char_byte;
        // A non-digit adds zero and flags the string.
        op_data.digit = is_digit ? digit_off[3:0] : 4'd0;
        if (fixed) begin
            op_data.bad = (s_data.char_byte != want);
        end else begin
            op_data.bad = (kind == hdsp_pkg::KIND_DIGIT) && !is_digit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 5'd0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

`ifndef SYNTH
    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_last) |=> (pos_reg == 5'd0))
        else $error("position did not wrap after the last byte");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/hdsp_fifo.sv =====
// Short queue of classified bytes between front and back.
`default_nettype none

module hdsp_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire hdsp_pkg::op_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output hdsp_pkg::op_t      pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hdsp_pkg::op_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid = (cnt_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign push_fire = push_valid && push_ready;
    assign pop_fire = pop_valid && pop_ready;

    always_comb begin
        cnt_next = cnt_reg;
        priority if (push_fire && !pop_fire) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop_fire && !push_fire) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_fire && !pop_fire) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/hdsp_back.sv =====
// Back end: name decode, digit accumulation, range checks and result register.
`default_nettype none

module hdsp_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             op_valid,
    output logic                  op_ready,
    input  wire hdsp_pkg::op_t    op_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output hdsp_pkg::out_word_t   m_data
);

    function automatic logic [3:0] day_lookup(input logic [23:0] name);
        logic [3:0] res;
        begin
            unique case (name)
                24'h53756E: res = 4'b1_000; // Sun
                24'h4D6F6E: res = 4'b1_001; // Mon
                24'h547565: res = 4'b1_010; // Tue
                24'h576564: res = 4'b1_011; // Wed
                24'h546875: res = 4'b1_100; // Thu
                24'h467269: res = 4'b1_101; // Fri
                24'h536174: res = 4'b1_110; // Sat
                default:    res = 4'b0_000;
            endcase
            return res;
        end
    endfunction

    function automatic logic [4:0] month_lookup(input logic [23:0] name);
        logic [4:0] res;
        begin
            unique case (name)
                24'h4A616E: res = 5'h10; // Jan
                24'h466562: res = 5'h11; // Feb
                24'h4D6172: res = 5'h12; // Mar
                24'h417072: res = 5'h13; // Apr
                24'h4D6179: res = 5'h14; // May
                24'h4A756E: res = 5'h15; // Jun
                24'h4A756C: res = 5'h16; // Jul
                24'h417567: res = 5'h17; // Aug
                24'h536570: res = 5'h18; // Sep
                24'h4F6374: res = 5'h19; // Oct
                24'h4E6F76: res = 5'h1A; // Nov
                24'h446563: res = 5'h1B; // Dec
                default:    res = 5'h00;
            endcase
            return res;
        end
    endfunction

    localparam int unsigned NF = hdsp_pkg::NUM_FIELDS;

    logic        err_reg, err_cur, err_next;
    logic [15:0] hold_reg, hold_cur, hold_next;
    logic [2:0]  wd_reg, wd_cur, wd_next;
    logic [3:0]  mon_reg, mon_cur, mon_next;
    logic [6:0]  acc_reg [NF];
    logic [6:0]  acc_cur [NF];
    logic [6:0]  acc_next [NF];
    logic [3:0]  day_hit;
    logic [4:0]  mon_hit;
    logic        out_free;
    logic        pop_fire;
    logic        fin_err;
    logic [6:0]  cent_off;
    logic [9:0]  years;
    logic        m_valid_reg, m_valid_next;
    hdsp_pkg::out_word_t m_data_reg, m_data_next;

    assign out_free = !m_valid_reg || m_ready;
    // Hold the last byte of a string until the result register can take it.
    assign op_ready = !op_data.last || out_free;
    assign pop_fire = op_valid && op_ready;

    assign day_hit = day_lookup({hold_cur, op_data.char_byte});
    assign mon_hit = month_lookup({hold_cur, op_data.char_byte});

    always_comb begin
        err_cur = op_data.start ? 1'b0 : err_reg;
        hold_cur = op_data.start ? 16'd0 : hold_reg;
        wd_cur = op_data.start ? 3'd0 : wd_reg;
        mon_cur = op_data.start ? 4'd0 : mon_reg;
        for (int i = 0; i < NF; i++) begin
            acc_cur[i] = op_data.start ? 7'd0 : acc_reg[i];
        end
    end

    always_comb begin
        err_next = err_cur | op_data.bad;
        hold_next = hold_cur;
        wd_next = wd_cur;
        mon_next = mon_cur;
        for (int i = 0; i < NF; i++) begin
            acc_next[i] = acc_cur[i];
        end
        unique case (op_data.kind)
            hdsp_pkg::KIND_HOLD_LO: begin
                hold_next = {8'd0, op_data.char_byte};
            end
            hdsp_pkg::KIND_HOLD_SHIFT: begin
                hold_next = {hold_cur[7:0], op_data.char_byte};
            end
            hdsp_pkg::KIND_DAY: begin
                if (day_hit[3]) begin
                    wd_next = day_hit[2:0];
                end else begin
                    err_next = 1'b1;
                end
            end
            hdsp_pkg::KIND_MON: begin
                if (mon_hit[4]) begin
                    mon_next = mon_hit[3:0];
                end else begin
                    err_next = 1'b1;
                end
            end
            hdsp_pkg::KIND_DIGIT: begin
                for (int i = 0; i < NF; i++) begin
                    if (op_data.field == 3'(i)) begin
                        // acc * 10 + digit, kept to seven bits
                        acc_next[i] = {acc_cur[i][3:0], 3'b000}
                                    + {acc_cur[i][5:0], 1'b0}
                                    + {3'b000, op_data.digit};
                    end
                end
            end
            default: begin
                hold_next = hold_cur;
            end
        endcase
    end

    // Final range checks; the accumulators are settled before the last byte.
    always_comb begin
        cent_off = acc_next[hdsp_pkg::FLD_CENT] - 7'd19;
        years = ({6'd0, cent_off[3:0]} * 10'd100) + {3'd0, acc_next[hdsp_pkg::FLD_YEAR]};
        fin_err = err_next
            || (acc_next[hdsp_pkg::FLD_CENT] < 7'd19)
            || (acc_next[hdsp_pkg::FLD_CENT] > 7'd29)
            || (acc_next[hdsp_pkg::FLD_YEAR] > 7'd99)
            || (acc_next[hdsp_pkg::FLD_DAY] < 7'd1)
            || (acc_next[hdsp_pkg::FLD_DAY] > 7'd31)
            || (acc_next[hdsp_pkg::FLD_HOUR] < 7'd1)
            || (acc_next[hdsp_pkg::FLD_HOUR] > 7'd24)
            || (acc_next[hdsp_pkg::FLD_MIN] > 7'd59)
            || (acc_next[hdsp_pkg::FLD_SEC] > 7'd59)
            || ((acc_next[hdsp_pkg::FLD_CENT] == 7'd29)
                && (acc_next[hdsp_pkg::FLD_YEAR] != 7'd0));
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        priority if (pop_fire && op_data.last) begin
            m_valid_next = 1'b1;
            m_data_next = '0;
            m_data_next.bad_format = fin_err;
            if (!fin_err) begin
                m_data_next.weekday = wd_next;
                m_data_next.month = mon_next;
                m_data_next.day_of_month = acc_next[hdsp_pkg::FLD_DAY][4:0];
                m_data_next.hours = acc_next[hdsp_pkg::FLD_HOUR][4:0];
                m_data_next.minutes = acc_next[hdsp_pkg::FLD_MIN][5:0];
                m_data_next.seconds = acc_next[hdsp_pkg::FLD_SEC][5:0];
                m_data_next.years_since_1900 = years;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= 1'b0;
            hold_reg <= 16'd0;
            wd_reg <= 3'd0;
            mon_reg <= 4'd0;
            for (int i = 0; i < NF; i++) begin
                acc_reg[i] <= 7'd0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop_fire) begin
                err_reg <= err_next;
                hold_reg <= hold_next;
                wd_reg <= wd_next;
                mon_reg <= mon_next;
                for (int i = 0; i < NF; i++) begin
                    acc_reg[i] <= acc_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

`ifndef SYNTH
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_fire && op_data.last) |=> m_valid)
        else $error("last byte consumed without a result");
    a_error_clears_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bad_format) |-> (m_data.weekday == 3'd0
            && m_data.month == 4'd0 && m_data.day_of_month == 5'd0
            && m_data.hours == 5'd0 && m_data.years_since_1900 == 10'd0))
        else $error("error result carries field values");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/http_date_string_parser.sv =====
// Top level of the HTTP date string parser.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_data  (hdsp_pkg::in_word_t)
//   m_       out        m_valid / m_ready   m_data  (hdsp_pkg::out_word_t)
//
// One byte is taken per cycle while the queue has room; the back end drains one byte per
// cycle unless a last byte waits. The 29th byte of a string loads the result register.
// Reset clears the position counter, the queue and m_valid; the result data is not reset.
// A stalled result holds the last byte in the queue; the queue then fills and drops s_ready.
`default_nettype none

module http_date_string_parser #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire hdsp_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output hdsp_pkg::out_word_t      m_data
);

    logic          fr_valid;
    logic          fr_ready;
    hdsp_pkg::op_t fr_op;
    logic          bk_valid;
    logic          bk_ready;
    hdsp_pkg::op_t bk_op;

    hdsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .op_valid (fr_valid),
        .op_ready (fr_ready),
        .op_data  (fr_op)
    );

    hdsp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_op),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_op)
    );

    hdsp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (bk_valid),
        .op_ready (bk_ready),
        .op_data  (bk_op),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
